FILE: hdl/ecap_pkg.sv
// Shared types and constants for the echo pulse capture block.
package ecap_pkg;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_EDGE  = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    localparam logic CFG_ENABLE  = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;

    localparam logic KIND_PULSE  = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

    typedef logic [LVL_W-1:0] t_level;

    // job leaving the front decode, before the rise time is known
    typedef struct packed {
        logic        is_pulse;
        logic [4:0]  pin;
        logic [31:0] now;
        logic [31:0] mask;
        logic        fin;
    } t_job;

    // queued work for the back end
    typedef struct packed {
        logic        is_pulse;
        logic [4:0]  pin;
        logic [31:0] dur;
        logic [31:0] mask;
        logic        fin;
    } t_entry;

endpackage

FILE: hdl/ecap_ram.sv
// Generic single-write, registered-read RAM.
module ecap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ecap_front.sv
// Front end: accepts beats, keeps measurement state, computes pulse widths.
module ecap_front #(
    parameter int NUM_PINS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_command,
    input  logic [4:0]        i_edge_pin,
    input  logic              i_edge_level,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  ecap_pkg::t_level  i_fifo_level,
    output logic              o_push,
    output ecap_pkg::t_entry  o_entry
);
    import ecap_pkg::*;

    localparam int RANGE  = (NUM_PINS < 32) ? NUM_PINS : 32;
    localparam int RAM_AW = (RANGE > 1) ? $clog2(RANGE) : 1;
    localparam logic [31:0] PIN_MASK = 32'((64'(1) << RANGE) - 64'(1));

    function automatic logic [5:0] popcount(input logic [31:0] v);
        logic [3:0] b [4];
        logic [5:0] s;
        for (int j = 0; j < 4; j++) begin
            b[j] = 4'd0;
            for (int k = 0; k < 8; k++) begin
                b[j] = b[j] + 4'(v[8*j + k]);
            end
        end
        s = 6'(b[0]) + 6'(b[1]) + 6'(b[2]) + 6'(b[3]);
        return s;
    endfunction

    logic [31:0] r_en;
    logic [31:0] r_timeout;
    logic        r_armed;
    logic [31:0] r_rose;
    logic [31:0] r_done;
    logic [31:0] r_now;
    logic [31:0] r_elapsed;
    logic [5:0]  r_pending;
    logic        r_stage_vld;
    t_job        r_job;

    logic        n_armed;
    logic [31:0] n_rose;
    logic [31:0] n_done;
    logic [31:0] n_now;
    logic [31:0] n_elapsed;
    logic [5:0]  n_pending;
    logic        n_stage_vld;
    t_job        n_job;

    logic [31:0]      w_group;
    logic             w_acc;
    logic             w_ram_we;
    logic [LVL_W:0]   w_used;
    logic [31:0]      w_rise;

    assign w_group = r_en & PIN_MASK;
    assign w_used  = (LVL_W+1)'(i_fifo_level) + (LVL_W+1)'(r_stage_vld);
    assign o_stall = w_used >= (LVL_W+1)'(FIFO_DEPTH);
    assign w_acc   = i_valid & ~o_stall;

    ecap_ram #(
        .WIDTH (32),
        .DEPTH (RANGE),
        .AW    (RAM_AW)
    ) u_rise_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_edge_pin[RAM_AW-1:0]),
        .i_wdata (r_now),
        .i_re    (w_acc),
        .i_raddr (i_edge_pin[RAM_AW-1:0]),
        .o_rdata (w_rise)
    );

    always_comb begin
        n_armed     = r_armed;
        n_rose      = r_rose;
        n_done      = r_done;
        n_now       = r_now;
        n_elapsed   = r_elapsed;
        n_pending   = r_pending;
        n_stage_vld = 1'b0;
        n_job       = '0;
        w_ram_we    = 1'b0;
        if (w_acc) begin
            unique case (i_command)
                CMD_START: begin
                    n_armed   = 1'b1;
                    n_rose    = '0;
                    n_done    = '0;
                    n_elapsed = '0;
                    n_pending = popcount(w_group);
                    if (n_pending == 6'd0) begin
                        n_armed      = 1'b0;
                        n_stage_vld  = 1'b1;
                        n_job.fin    = 1'b1;
                    end
                end
                CMD_TICK: begin
                    n_now = r_now + 32'd1;
                    if (r_armed) begin
                        if (r_elapsed != '1) begin
                            n_elapsed = r_elapsed + 32'd1;
                        end
                        if (n_elapsed >= r_timeout) begin
                            n_armed     = 1'b0;
                            n_stage_vld = 1'b1;
                            n_job.fin   = 1'b1;
                            n_job.mask  = r_done;
                        end
                    end
                end
                CMD_EDGE: begin
                    if (r_armed && w_group[i_edge_pin] && !r_done[i_edge_pin]) begin
                        if (i_edge_level && !r_rose[i_edge_pin]) begin
                            w_ram_we             = 1'b1;
                            n_rose[i_edge_pin]   = 1'b1;
                        end else if (r_rose[i_edge_pin]) begin
                            n_done[i_edge_pin] = 1'b1;
                            if (r_pending != 6'd0) begin
                                n_pending = r_pending - 6'd1;
                            end
                            n_stage_vld    = 1'b1;
                            n_job.is_pulse = 1'b1;
                            n_job.pin      = i_edge_pin;
                            n_job.now      = r_now;
                            n_job.mask     = n_done;
                            n_job.fin      = (n_pending == 6'd0);
                            if (n_pending == 6'd0) begin
                                n_armed = 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en        <= '0;
            r_timeout   <= TIMEOUT_RESET;
            r_armed     <= 1'b0;
            r_rose      <= '0;
            r_done      <= '0;
            r_now       <= '0;
            r_elapsed   <= '0;
            r_pending   <= '0;
            r_stage_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ENABLE:  r_en      <= i_cfg_data;
                    CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    default: ;
                endcase
            end
            r_armed     <= n_armed;
            r_rose      <= n_rose;
            r_done      <= n_done;
            r_now       <= n_now;
            r_elapsed   <= n_elapsed;
            r_pending   <= n_pending;
            r_stage_vld <= n_stage_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    assign o_push           = r_stage_vld;
    assign o_entry.is_pulse = r_job.is_pulse;
    assign o_entry.pin      = r_job.pin;
    assign o_entry.dur      = r_job.is_pulse ? (r_job.now - w_rise) : 32'd0;
    assign o_entry.mask     = r_job.mask;
    assign o_entry.fin      = r_job.fin;

endmodule

FILE: hdl/ecap_fifo.sv
// Short queue between the front end and the result sequencer.
module ecap_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ecap_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output ecap_pkg::t_entry  o_entry,
    output logic              o_empty,
    output ecap_pkg::t_level  o_level
);
    import ecap_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    t_entry           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    t_level           r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + LVL_W'(1);
            end else if (i_pop && !i_push) begin
                r_level <= r_level - LVL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    assign o_entry = r_mem[r_rd];
    assign o_empty = (r_level == '0);
    assign o_level = r_level;

endmodule

FILE: hdl/ecap_back.sv
// Back end: expands queued entries into result beats behind an output register.
module ecap_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ecap_pkg::t_entry  i_entry,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_result_kind,
    output logic [4:0]        o_channel,
    output logic [31:0]       o_duration_ticks,
    output logic [31:0]       o_valid_mask,
    output logic              o_mask_nonzero,
    output logic              o_last
);
    import ecap_pkg::*;

    logic        r_vld;
    logic        r_half;
    logic        r_kind;
    logic [4:0]  r_chan;
    logic [31:0] r_dur;
    logic [31:0] r_mask;
    logic        r_any;
    logic        r_last;

    logic w_load;
    logic w_fin_beat;

    assign w_load     = ~i_empty & (~r_vld | ~i_stall);
    assign w_fin_beat = r_half | ~i_entry.is_pulse;
    assign o_pop      = w_load & (w_fin_beat | ~i_entry.fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_half <= 1'b0;
        end else begin
            if (w_load) begin
                r_vld  <= 1'b1;
                r_half <= ~w_fin_beat & i_entry.fin;
            end else if (!i_stall) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mask <= i_entry.mask;
            r_any  <= (i_entry.mask != '0);
            if (w_fin_beat) begin
                r_kind <= KIND_FINISH;
                r_chan <= '0;
                r_dur  <= '0;
                r_last <= 1'b1;
            end else begin
                r_kind <= KIND_PULSE;
                r_chan <= i_entry.pin;
                r_dur  <= i_entry.dur;
                r_last <= ~i_entry.fin;
            end
        end
    end

    assign o_valid          = r_vld;
    assign o_result_kind    = r_kind;
    assign o_channel        = r_chan;
    assign o_duration_ticks = r_dur;
    assign o_valid_mask     = r_mask;
    assign o_mask_nonzero   = r_any;
    assign o_last           = r_last;

endmodule

FILE: hdl/multi_channel_echo_pulse_capture.sv
// Top level of the multi-channel echo pulse width capture block.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   i_command, i_edge_pin, i_edge_level
//   result    out        o_valid / i_stall   o_result_kind, o_channel, o_duration_ticks,
//                                            o_valid_mask, o_mask_nonzero, o_last
//   config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// One input beat per cycle while o_stall is low; a result passes through decode and
// rise-time read, queue write and the output register.
// A completing edge that ends the measurement gives two result beats, a pulse then a finish.
// o_stall rises when the four-entry queue plus the in-flight stage would overflow.
// Synchronous active-low reset; no clearing pass, the rise-time RAM is written before read.
module multi_channel_echo_pulse_capture #(
    parameter int NUM_PINS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [4:0]  i_edge_pin,
    input  logic        i_edge_level,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [4:0]  o_channel,
    output logic [31:0] o_duration_ticks,
    output logic [31:0] o_valid_mask,
    output logic        o_mask_nonzero,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import ecap_pkg::*;

    logic   w_push;
    logic   w_pop;
    logic   w_empty;
    t_entry w_push_entry;
    t_entry w_head;
    t_level w_level;

    ecap_front #(
        .NUM_PINS (NUM_PINS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_edge_pin   (i_edge_pin),
        .i_edge_level (i_edge_level),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_fifo_level (w_level),
        .o_push       (w_push),
        .o_entry      (w_push_entry)
    );

    ecap_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head),
        .o_empty (w_empty),
        .o_level (w_level)
    );

    ecap_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_entry          (w_head),
        .i_empty          (w_empty),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_kind    (o_result_kind),
        .o_channel        (o_channel),
        .o_duration_ticks (o_duration_ticks),
        .o_valid_mask     (o_valid_mask),
        .o_mask_nonzero   (o_mask_nonzero),
        .o_last           (o_last)
    );

endmodule

FILE: tb/multi_channel_echo_pulse_capture_tb.sv
// Self-checking testbench for the multi-channel echo pulse capture block.
`timescale 1ns / 1ps

module multi_channel_echo_pulse_capture_tb;
    import ecap_pkg::*;

    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         RANDOM_BEATS  = 1800;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic        kind;
        logic [4:0]  ch;
        logic [31:0] dur;
        logic [31:0] mask;
        logic        any;
        logic        lst;
    } t_report;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PREDICT,
        ROW_NONE,
        ROW_ONE
    } t_row_kind;

    typedef struct packed {
        t_row_kind   how;
        logic [1:0]  cmd;
        logic [4:0]  pin;
        logic        lvl;
        logic        cfg_idx;
        logic [31:0] cfg_data;
        t_report     rep;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_command;
    logic [4:0]  i_edge_pin;
    logic        i_edge_level;
    logic        o_valid;
    logic        i_stall;
    logic        o_result_kind;
    logic [4:0]  o_channel;
    logic [31:0] o_duration_ticks;
    logic [31:0] o_valid_mask;
    logic        o_mask_nonzero;
    logic        o_last;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;

    // predicted block state
    logic [31:0] c_enable;
    logic [31:0] c_timeout;
    logic        p_armed;
    logic [31:0] p_rose;
    logic [31:0] p_done;
    logic [31:0] p_rise [32];
    logic [31:0] p_now;
    logic [31:0] p_elapsed;
    logic [5:0]  p_left;

    t_report echo_reports_q [$];
    t_row    plan [$];
    int      mismatches   = 0;
    int      sent_beats   = 0;
    int      cycle_count  = 0;
    bit      calm         = 1'b0;

    multi_channel_echo_pulse_capture dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_edge_pin       (i_edge_pin),
        .i_edge_level     (i_edge_level),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_kind    (o_result_kind),
        .o_channel        (o_channel),
        .o_duration_ticks (o_duration_ticks),
        .o_valid_mask     (o_valid_mask),
        .o_mask_nonzero   (o_mask_nonzero),
        .o_last           (o_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void close_measure(input bit emit);
        if (emit) begin
            echo_reports_q.push_back({KIND_FINISH, 5'd0, 32'd0, p_done, |p_done, 1'b1});
        end
        p_armed = 1'b0;
    endfunction

    // Advances the predicted state by one beat; returns 1 when the beat had an effect.
    function automatic bit predict_echo(input logic [1:0] cmd, input logic [4:0] pin,
                                        input logic lvl, input bit emit);
        logic [31:0] pin_bit;
        logic [31:0] span;
        pin_bit = 32'd1 << pin;
        case (cmd)
            CMD_START: begin
                p_armed   = 1'b1;
                p_rose    = '0;
                p_done    = '0;
                p_elapsed = '0;
                p_left    = 6'($countones(c_enable));
                if (p_left == 6'd0) close_measure(emit);
                return 1'b1;
            end
            CMD_TICK: begin
                p_now = p_now + 32'd1;
                if (p_armed) begin
                    if (p_elapsed != 32'hFFFF_FFFF) p_elapsed = p_elapsed + 32'd1;
                    if (p_elapsed >= c_timeout) close_measure(emit);
                end
                return 1'b1;
            end
            CMD_EDGE: begin
                if (!p_armed || (c_enable & pin_bit) == '0 || (p_done & pin_bit) != '0) begin
                    return 1'b0;
                end
                if (lvl && (p_rose & pin_bit) == '0) begin
                    p_rise[pin] = p_now;
                    p_rose      = p_rose | pin_bit;
                    return 1'b1;
                end
                if ((p_rose & pin_bit) != '0) begin
                    span   = p_now - p_rise[pin];
                    p_done = p_done | pin_bit;
                    if (p_left != 6'd0) p_left = p_left - 6'd1;
                    if (emit) begin
                        echo_reports_q.push_back({KIND_PULSE, pin, span, p_done, |p_done,
                                                  p_left != 6'd0});
                    end
                    if (p_left == 6'd0) close_measure(emit);
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void beat_row(input t_row_kind how, input logic [1:0] cmd,
                                     input logic [4:0] pin, input logic lvl);
        t_row r;
        r     = '0;
        r.how = how;
        r.cmd = cmd;
        r.pin = pin;
        r.lvl = lvl;
        plan.push_back(r);
    endfunction

    function automatic void hit_row(input logic [1:0] cmd, input logic [4:0] pin,
                                    input logic lvl, input logic kind, input logic [4:0] ch,
                                    input logic [31:0] dur, input logic [31:0] mask);
        t_row r;
        r     = '0;
        r.how = ROW_ONE;
        r.cmd = cmd;
        r.pin = pin;
        r.lvl = lvl;
        r.rep = {kind, ch, dur, mask, |mask, 1'b1};
        plan.push_back(r);
    endfunction

    function automatic void cfg_row(input logic idx, input logic [31:0] data);
        t_row r;
        r          = '0;
        r.how      = ROW_CFG;
        r.cfg_idx  = idx;
        r.cfg_data = data;
        plan.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_beat(input logic [1:0] cmd, input logic [4:0] pin, input logic lvl,
                             input bit emit);
        int gap;
        gap = calm ? 0 : int'($urandom_range(0, 9));
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_edge_pin   <= pin;
        i_edge_level <= lvl;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        void'(predict_echo(cmd, pin, lvl, emit));
        sent_beats++;
    endtask

    // wait out all expected beats, then the pipeline depth
    task automatic settle();
        i_valid <= 1'b0;
        while (echo_reports_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] data);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ENABLE) c_enable = data;
        else c_timeout = data;
    endtask

    initial begin : result_side
        int      hold;
        t_report want;
        t_report got;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = calm ? 0 : int'($urandom_range(0, 9));
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_valid !== 1'b1);
            got = {o_result_kind, o_channel, o_duration_ticks, o_valid_mask, o_mask_nonzero,
                   o_last};
            if (echo_reports_q.size() == 0) begin
                $error("result beat with nothing expected: kind %0d channel %0d mask %0h",
                       got.kind, got.ch, got.mask);
                mismatches++;
            end else begin
                want = echo_reports_q.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(got.kind));
                check_field("channel", 32'(want.ch), 32'(got.ch));
                check_field("duration_ticks", want.dur, got.dur);
                check_field("valid_mask", want.mask, got.mask);
                check_field("mask_nonzero", 32'(want.any), 32'(got.any));
                check_field("last", 32'(want.lst), 32'(got.lst));
            end
        end
    end

    initial begin : stimulus
        logic [31:0] en;
        logic [31:0] tmo;
        int          roll;
        int          p;

        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_command    <= CMD_START;
        i_edge_pin   <= 5'd0;
        i_edge_level <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_ENABLE;
        i_cfg_data   <= 32'd0;

        c_enable  = 32'd0;
        c_timeout = TIMEOUT_RESET;
        p_armed   = 1'b0;
        p_rose    = '0;
        p_done    = '0;
        p_now     = '0;
        p_elapsed = '0;
        p_left    = '0;

        // empty group, unarmed edge and tick, unknown command
        hit_row(CMD_START, 5'd0, 1'b0, KIND_FINISH, 5'd0, 32'd0, 32'd0);
        beat_row(ROW_NONE, CMD_EDGE, 5'd31, 1'b1);
        beat_row(ROW_NONE, CMD_TICK, 5'd0, 1'b0);
        beat_row(ROW_NONE, CMD_UNUSED, 5'd31, 1'b1);
        cfg_row(CFG_ENABLE, 32'h8000_0003);
        cfg_row(CFG_TIMEOUT, 32'hFFFF_FFFF);
        // disabled pin, low before rise, high edge completing a risen pin
        beat_row(ROW_NONE, CMD_START, 5'd0, 1'b0);
        beat_row(ROW_NONE, CMD_EDGE, 5'd2, 1'b1);
        beat_row(ROW_NONE, CMD_EDGE, 5'd0, 1'b0);
        beat_row(ROW_NONE, CMD_EDGE, 5'd0, 1'b1);
        beat_row(ROW_NONE, CMD_TICK, 5'd0, 1'b0);
        beat_row(ROW_NONE, CMD_TICK, 5'd0, 1'b0);
        hit_row(CMD_EDGE, 5'd0, 1'b1, KIND_PULSE, 5'd0, 32'd2, 32'h0000_0001);
        beat_row(ROW_NONE, CMD_EDGE, 5'd0, 1'b0);
        beat_row(ROW_NONE, CMD_EDGE, 5'd31, 1'b1);
        beat_row(ROW_NONE, CMD_TICK, 5'd0, 1'b0);
        hit_row(CMD_EDGE, 5'd31, 1'b0, KIND_PULSE, 5'd31, 32'd1, 32'h8000_0001);
        beat_row(ROW_NONE, CMD_EDGE, 5'd1, 1'b1);
        beat_row(ROW_PREDICT, CMD_EDGE, 5'd1, 1'b0);
        // restart while armed, then enable narrowed while armed
        beat_row(ROW_NONE, CMD_START, 5'd0, 1'b0);
        beat_row(ROW_NONE, CMD_EDGE, 5'd1, 1'b1);
        beat_row(ROW_NONE, CMD_START, 5'd0, 1'b0);
        beat_row(ROW_NONE, CMD_EDGE, 5'd1, 1'b0);
        cfg_row(CFG_ENABLE, 32'h0000_0001);
        beat_row(ROW_NONE, CMD_EDGE, 5'd31, 1'b1);
        beat_row(ROW_NONE, CMD_EDGE, 5'd0, 1'b1);
        beat_row(ROW_PREDICT, CMD_EDGE, 5'd0, 1'b0);
        // timeouts
        cfg_row(CFG_ENABLE, 32'hFFFF_FFFF);
        cfg_row(CFG_TIMEOUT, 32'd1);
        beat_row(ROW_NONE, CMD_START, 5'd0, 1'b0);
        hit_row(CMD_TICK, 5'd0, 1'b0, KIND_FINISH, 5'd0, 32'd0, 32'd0);
        beat_row(ROW_NONE, CMD_TICK, 5'd0, 1'b0);
        cfg_row(CFG_TIMEOUT, 32'd3);
        beat_row(ROW_NONE, CMD_START, 5'd0, 1'b0);
        beat_row(ROW_NONE, CMD_EDGE, 5'd7, 1'b1);
        beat_row(ROW_NONE, CMD_TICK, 5'd0, 1'b0);
        beat_row(ROW_NONE, CMD_TICK, 5'd0, 1'b0);
        beat_row(ROW_PREDICT, CMD_TICK, 5'd0, 1'b0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            case (plan[i].how)
                ROW_CFG: cfg_write(plan[i].cfg_idx, plan[i].cfg_data);
                ROW_PREDICT: send_beat(plan[i].cmd, plan[i].pin, plan[i].lvl, 1'b1);
                ROW_NONE: send_beat(plan[i].cmd, plan[i].pin, plan[i].lvl, 1'b0);
                default: begin
                    send_beat(plan[i].cmd, plan[i].pin, plan[i].lvl, 1'b0);
                    echo_reports_q.push_back(plan[i].rep);
                end
            endcase
        end

        sent_beats = 0;
        while (sent_beats < RANDOM_BEATS) begin
            case ($urandom_range(0, 7))
                0: en = 32'd0;
                1: en = 32'hFFFF_FFFF;
                2: en = $urandom;
                default: begin
                    en = 32'd0;
                    repeat ($urandom_range(1, 4)) en[$urandom_range(0, 31)] = 1'b1;
                end
            endcase
            case ($urandom_range(0, 5))
                0: tmo = 32'd1;
                1: tmo = 32'hFFFF_FFFF;
                2: tmo = TIMEOUT_RESET;
                default: tmo = $urandom_range(2, 40);
            endcase
            cfg_write(CFG_ENABLE, en);
            cfg_write(CFG_TIMEOUT, tmo);
            calm = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 7) != 0) send_beat(CMD_START, 5'd0, 1'b0, 1'b1);
                repeat ($urandom_range(4, 48)) begin
                    roll = int'($urandom_range(0, 99));
                    if (roll < 40) begin
                        send_beat(CMD_TICK, 5'($urandom_range(0, 31)),
                                  1'($urandom_range(0, 1)), 1'b1);
                    end else if (roll < 85 && en != 32'd0) begin
                        do p = int'($urandom_range(0, 31)); while (!en[p]);
                        send_beat(CMD_EDGE, 5'(p), $urandom_range(0, 3) != 0, 1'b1);
                    end else if (roll < 95) begin
                        send_beat(CMD_EDGE, 5'($urandom_range(0, 31)),
                                  1'($urandom_range(0, 1)), 1'b1);
                    end else if (roll < 98) begin
                        send_beat(CMD_UNUSED, 5'($urandom_range(0, 31)),
                                  1'($urandom_range(0, 1)), 1'b1);
                    end else begin
                        send_beat(CMD_START, 5'($urandom_range(0, 31)),
                                  1'($urandom_range(0, 1)), 1'b1);
                    end
                end
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/ecap_pkg.sv
hdl/ecap_ram.sv
hdl/ecap_front.sv
hdl/ecap_fifo.sv
hdl/ecap_back.sv
hdl/multi_channel_echo_pulse_capture.sv
tb/multi_channel_echo_pulse_capture_tb.sv
